/* hw/rtl/multipoint_strip_gain_correction_macros.svh */
// Assertion macros for the checker file
`ifndef MULTIPOINT_STRIP_GAIN_CORRECTION_MACROS_SVH
`define MULTIPOINT_STRIP_GAIN_CORRECTION_MACROS_SVH

// Property checked only outside reset
`define MSGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define MSGC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/msgc_pkg.sv */
package msgc_pkg;

    // input function codes
    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SKIP  = 2'd1;
    localparam logic [1:0] FUNC_PIXEL = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 40;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SKIP,
        OP_PIXEL,
        OP_PIXBAD
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [9:0]          strip;
        logic [3:0]          slot;
        logic signed [23:0]  level;
        logic signed [23:0]  resp;
        logic                skip;
        logic signed [15:0]  pixel;
    } t_entry;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_DIV,
        B_WRITE,
        B_PREAD,
        B_SCAN,
        B_FREAD,
        B_MUL,
        B_OUT
    } t_bstate;

endpackage

/* hw/rtl/msgc_ram.sv */
module msgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/msgc_div.sv */
module msgc_div import msgc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_dividend,
    input  logic [23:0] i_divisor,
    output logic        o_done,
    output logic [39:0] o_quot
);

    logic [39:0] r_quot;
    logic [23:0] r_rem;
    logic [23:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [24:0] trial;
    logic        ge;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quot[39]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? 24'(trial - {1'b0, r_div}) : trial[23:0];
            r_quot <= {r_quot[38:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* hw/rtl/msgc_queue.sv */
module msgc_queue import msgc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_entry        r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_full  = r_count == (PW+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_slot[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

/* hw/rtl/msgc_front.sv */
module msgc_front import msgc_pkg::*; #(
    parameter int NUM_LEVELS = 16,
    parameter int NUM_STRIPS = 1024
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [79:0] i_data,
    input  logic [1:0]  i_func,
    input  logic        i_full,
    input  logic        i_clearing,
    output logic        o_push,
    output t_entry      o_entry
);

    logic strip_ok;
    logic slot_ok;
    logic keep;

    assign o_ready  = !i_full && !i_clearing;
    assign strip_ok = 13'(i_data[9:0]) < 13'(NUM_STRIPS);
    assign slot_ok  = 8'(i_data[13:10]) < 8'(NUM_LEVELS);

    // unpack fields and classify; dropped items never reach the queue
    always_comb begin
        o_entry.strip = i_data[9:0];
        o_entry.slot  = i_data[13:10];
        o_entry.level = i_data[37:14];
        o_entry.resp  = i_data[61:38];
        o_entry.skip  = i_data[62];
        o_entry.pixel = i_data[78:63];
        o_entry.op    = OP_PIXBAD;
        keep          = 1'b0;
        unique case (i_func)
            FUNC_LOAD: begin
                o_entry.op = OP_LOAD;
                keep       = strip_ok && slot_ok;
            end
            FUNC_SKIP: begin
                o_entry.op = OP_SKIP;
                keep       = strip_ok;
            end
            FUNC_PIXEL: begin
                o_entry.op = strip_ok ? OP_PIXEL : OP_PIXBAD;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_valid && o_ready && keep;

endmodule

/* hw/rtl/msgc_back.sv */
module msgc_back import msgc_pkg::*; #(
    parameter int NUM_LEVELS = 16,
    parameter int NUM_STRIPS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_entry      i_q_entry,
    output logic        o_q_pop,
    input  logic [(NUM_LEVELS > 1 ? $clog2(NUM_LEVELS + 1) : 1)-1:0] i_nlev,
    output logic        o_clearing,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pixel,
    output logic        o_sat,
    output logic        o_skipped,
    output logic [3:0]  o_level
);

    localparam int KW   = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS + 1) : 1;
    localparam int LW   = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS) : 1;
    localparam int SAW  = NUM_STRIPS > 1 ? $clog2(NUM_STRIPS) : 1;
    localparam int TDEP = NUM_STRIPS * NUM_LEVELS;
    localparam int TAW  = TDEP > 1 ? $clog2(TDEP) : 1;

    t_bstate            r_state, n_state;
    t_entry             r_entry, n_entry;
    logic [SAW-1:0]     r_clr, n_clr;
    logic [KW-1:0]      r_k, n_k;
    logic [LW-1:0]      r_best, n_best;
    logic [24:0]        r_bestd, n_bestd;
    logic signed [47:0] r_prod, n_prod;
    logic [31:0]        r_factor, n_factor;
    logic [23:0]        r_resw, n_resw;
    logic               r_skipres, n_skipres;
    logic               r_out_valid, n_out_valid;
    logic [15:0]        r_out_pix, n_out_pix;
    logic               r_out_sat, n_out_sat;
    logic               r_out_skip, n_out_skip;
    logic [3:0]         r_out_lvl, n_out_lvl;

    logic               skip_we, skip_wdata, skip_rdata;
    logic [SAW-1:0]     skip_waddr;
    logic               tab_we;
    logic [TAW-1:0]     tab_waddr, tab_raddr;
    logic [23:0]        resp_rdata;
    logic [31:0]        fact_rdata;
    logic [31:0]        tab_base;
    logic [KW-1:0]      rd_k;

    logic               div_start, div_done;
    logic [39:0]        div_quot;
    logic [23:0]        lvl_mag, resp_mag;

    logic [24:0]        dist_s, abs_dist;
    logic signed [47:0] adj;
    logic signed [31:0] quo;
    logic               neg_q;

    // skip marks and the two calibration tables
    msgc_ram #(.WIDTH(1), .DEPTH(NUM_STRIPS)) u_skip_ram (
        .i_clk   (i_clk),
        .i_we    (skip_we),
        .i_waddr (skip_waddr),
        .i_wdata (skip_wdata),
        .i_raddr (SAW'(r_entry.strip)),
        .o_rdata (skip_rdata)
    );

    msgc_ram #(.WIDTH(24), .DEPTH(TDEP)) u_resp_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (r_resw),
        .i_raddr (tab_raddr),
        .o_rdata (resp_rdata)
    );

    msgc_ram #(.WIDTH(32), .DEPTH(TDEP)) u_fact_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (r_factor),
        .i_raddr (tab_raddr),
        .o_rdata (fact_rdata)
    );

    // magnitude divider for level * 65536 / response
    assign lvl_mag  = i_q_entry.level[23] ? 24'(-i_q_entry.level) : i_q_entry.level;
    assign resp_mag = i_q_entry.resp[23]  ? 24'(-i_q_entry.resp)  : i_q_entry.resp;
    assign neg_q    = r_entry.level[23] ^ r_entry.resp[23];

    msgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({lvl_mag, 16'h0000}),
        .i_divisor  (resp_mag),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // table addressing
    assign tab_base  = 32'(r_entry.strip) * NUM_LEVELS;
    assign tab_waddr = TAW'(tab_base + 32'(r_entry.slot));

    // distance of the returned response to the pixel, Q16.8
    assign dist_s   = {resp_rdata[23], resp_rdata}
                    - {r_entry.pixel[15], r_entry.pixel, 8'h00};
    assign abs_dist = dist_s[24] ? 25'(-dist_s) : dist_s;

    // truncate toward zero, then take the integer part
    assign adj = r_prod + (r_prod < 0 ? 48'sd65535 : 48'sd0);
    assign quo = 32'(adj >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry    <= n_entry;
        r_k        <= n_k;
        r_best     <= n_best;
        r_bestd    <= n_bestd;
        r_prod     <= n_prod;
        r_factor   <= n_factor;
        r_resw     <= n_resw;
        r_skipres  <= n_skipres;
        r_out_pix  <= n_out_pix;
        r_out_sat  <= n_out_sat;
        r_out_skip <= n_out_skip;
        r_out_lvl  <= n_out_lvl;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_entry     = r_entry;
        n_clr       = r_clr;
        n_k         = r_k;
        n_best      = r_best;
        n_bestd     = r_bestd;
        n_prod      = r_prod;
        n_factor    = r_factor;
        n_resw      = r_resw;
        n_skipres   = r_skipres;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pix   = r_out_pix;
        n_out_sat   = r_out_sat;
        n_out_skip  = r_out_skip;
        n_out_lvl   = r_out_lvl;
        o_q_pop     = 1'b0;
        skip_we     = 1'b0;
        skip_waddr  = SAW'(i_q_entry.strip);
        skip_wdata  = i_q_entry.skip;
        tab_we      = 1'b0;
        div_start   = 1'b0;
        rd_k        = r_k;
        unique case (r_state)
            B_CLEAR: begin
                skip_we    = 1'b1;
                skip_waddr = r_clr;
                skip_wdata = 1'b0;
                if (r_clr == SAW'(NUM_STRIPS - 1)) begin
                    n_state = B_IDLE;
                end else begin
                    n_clr = r_clr + SAW'(1);
                end
            end
            B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_entry = i_q_entry;
                    unique case (i_q_entry.op)
                        OP_LOAD: begin
                            if (i_q_entry.resp == '0) begin
                                n_resw   = 24'd256;
                                n_factor = {{8{i_q_entry.level[23]}}, i_q_entry.level} << 8;
                                n_state  = B_WRITE;
                            end else begin
                                n_resw    = i_q_entry.resp;
                                div_start = 1'b1;
                                n_state   = B_DIV;
                            end
                        end
                        OP_SKIP: begin
                            skip_we = 1'b1;
                        end
                        OP_PIXEL: begin
                            n_k     = '0;
                            n_state = B_PREAD;
                        end
                        OP_PIXBAD: begin
                            n_skipres = 1'b1;
                            n_state   = B_OUT;
                        end
                        default: begin
                            n_state = B_IDLE;
                        end
                    endcase
                end
            end
            B_DIV: begin
                if (div_done) begin
                    if (neg_q) begin
                        n_factor = (div_quot > 40'h0080000000) ? 32'h8000_0000
                                                               : 32'(-div_quot);
                    end else begin
                        n_factor = (div_quot > 40'h007FFFFFFF) ? 32'h7FFF_FFFF
                                                               : div_quot[31:0];
                    end
                    n_state = B_WRITE;
                end
            end
            B_WRITE: begin
                tab_we  = 1'b1;
                n_state = B_IDLE;
            end
            B_PREAD: begin
                n_k     = KW'(1);
                n_state = B_SCAN;
            end
            B_SCAN: begin
                // response of slot r_k-1 is on the read port
                if (r_k == KW'(1) && skip_rdata) begin
                    n_skipres = 1'b1;
                    n_state   = B_OUT;
                end else begin
                    if (r_k == KW'(1) || abs_dist < r_bestd) begin
                        n_bestd = abs_dist;
                        n_best  = LW'(r_k - KW'(1));
                    end
                    if (r_k == i_nlev) begin
                        n_state = B_FREAD;
                    end else begin
                        n_k = r_k + KW'(1);
                    end
                end
            end
            B_FREAD: begin
                n_state = B_MUL;
            end
            B_MUL: begin
                n_prod    = $signed(fact_rdata) * r_entry.pixel;
                n_skipres = 1'b0;
                n_state   = B_OUT;
            end
            B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_skip  = r_skipres;
                    if (r_skipres) begin
                        n_out_pix = '0;
                        n_out_sat = 1'b0;
                        n_out_lvl = '0;
                    end else begin
                        n_out_lvl = 4'(r_best);
                        if (quo > 32'sd32767) begin
                            n_out_pix = 16'h7FFF;
                            n_out_sat = 1'b1;
                        end else if (quo < -32'sd32768) begin
                            n_out_pix = 16'h8000;
                            n_out_sat = 1'b1;
                        end else begin
                            n_out_pix = quo[15:0];
                            n_out_sat = 1'b0;
                        end
                    end
                    n_skipres = 1'b0;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        if (r_state == B_FREAD) begin
            tab_raddr = TAW'(tab_base + 32'(r_best));
        end else begin
            tab_raddr = TAW'(tab_base + 32'(rd_k));
        end
    end

    assign o_clearing = r_state == B_CLEAR;
    assign o_valid    = r_out_valid;
    assign o_pixel    = r_out_pix;
    assign o_sat      = r_out_sat;
    assign o_skipped  = r_out_skip;
    assign o_level    = r_out_lvl;

endmodule

/* hw/rtl/multipoint_strip_gain_correction.sv */
// Per-strip multipoint gain correction. Input transfers carry a function code in
// tuser: load a calibration level/response pair, set a strip's skip mark, or
// correct a pixel. A front end classifies each transfer into a four-entry queue
// and a back end executes it, so intake continues while a result waits on the
// output register. A pixel scans the response table through its single read port,
// one level per cycle. A load runs the 40-step restoring divider unless the
// response is zero. After reset the skip marks are cleared, during which tready
// stays low. Loading a level slot before a pixel uses it is the user's duty;
// unloaded slots return arbitrary data.
module multipoint_strip_gain_correction import msgc_pkg::*; #(
    parameter int NUM_LEVELS = 16,
    parameter int NUM_STRIPS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,    // num_levels
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // strip[9:0], level_index[13:10], level_value[37:14],
    // response_value[61:38], skip_flag[62], pixel_value[78:63], zero[79]
    input  logic [79:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser, // func[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // calibrated_pixel[15:0], chosen_level[19:16], zero[23:20]
    output logic [23:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser  // saturated[0], strip_skipped[1]
);

    localparam int KW = NUM_LEVELS > 1 ? $clog2(NUM_LEVELS + 1) : 1;

    logic [4:0]    r_num_levels;
    logic [7:0]    nl8;
    logic [KW-1:0] nlev;
    logic          q_push, q_full, q_pop, q_valid, clearing;
    t_entry        f_entry, q_entry;
    logic [15:0]   out_pix;
    logic [3:0]    out_lvl;
    logic          out_sat, out_skip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= 5'd16;
        end else if (i_cfg_we) begin
            r_num_levels <= i_cfg_wdata;
        end
    end

    // level count clamped to 1..NUM_LEVELS
    assign nl8  = 8'(r_num_levels);
    assign nlev = (nl8 == 8'd0) ? KW'(1)
                : (nl8 > 8'(NUM_LEVELS)) ? KW'(NUM_LEVELS) : KW'(nl8);

    msgc_front #(.NUM_LEVELS(NUM_LEVELS), .NUM_STRIPS(NUM_STRIPS)) u_front (
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (i_s_axis_tdata),
        .i_func     (i_s_axis_tuser),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_push     (q_push),
        .o_entry    (f_entry)
    );

    msgc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    msgc_back #(.NUM_LEVELS(NUM_LEVELS), .NUM_STRIPS(NUM_STRIPS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_q_pop    (q_pop),
        .i_nlev     (nlev),
        .o_clearing (clearing),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_pixel    (out_pix),
        .o_sat      (out_sat),
        .o_skipped  (out_skip),
        .o_level    (out_lvl)
    );

    assign o_m_axis_tdata = {4'h0, out_lvl, out_pix};
    assign o_m_axis_tuser = {out_skip, out_sat};

endmodule

/* hw/rtl/msgc_checker.sv */
`include "multipoint_strip_gain_correction_macros.svh"

module msgc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [4:0]  i_cfg_wdata,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [79:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // a result held back by the sink keeps its contents
    `MSGC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // skipped strips give an all-zero result
    `MSGC_ASSERT(a_skip_zero, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tdata == 24'h0 && !o_m_axis_tuser[0], "skipped strip result not zero")

    // saturation only reports a clipped value
    `MSGC_ASSERT(a_sat_clip, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[15:0] == 16'h7FFF || o_m_axis_tdata[15:0] == 16'h8000, "saturated flag on unclipped value")

    // clearing pass follows reset: no intake, no result
    `MSGC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid, "activity right after reset")

endmodule

bind multipoint_strip_gain_correction msgc_checker u_msgc_checker (.*);
